### rtl/core/earliest_free_worker_assigner_unit_assert.svh
// Assertion macros for the earliest-free worker assigner.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef EARLIEST_FREE_WORKER_ASSIGNER_UNIT_ASSERT_SVH
`define EARLIEST_FREE_WORKER_ASSIGNER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EFWA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define EFWA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/efwa_pkg.sv
// ----------------------------------------------------------------------------
// efwa_pkg
// Shared widths, defaults and control types of the earliest-free worker
// assigner.
// ----------------------------------------------------------------------------
package efwa_pkg;

	// Field widths fixed by the interface.
	localparam int DUR_W   = 32;
	localparam int TIME_W  = 48;
	localparam int IDX_W   = 4;
	localparam int COUNT_W = 5;

	// Default number of workers built.
	localparam int MAX_WORKERS_DEF = 16;

	// Reset value of the worker count register.
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

	// Largest representable time; sums saturate here.
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // take a new item and restart the scan
		logic scan;    // examine one worker entry
		logic commit;  // write back the free time and present the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;  // the entry under examination is the last active one
		logic out_free;   // the output register can take a result this cycle
	} sts_t;

endpackage

### rtl/core/efwa_if.sv
// ----------------------------------------------------------------------------
// efwa_job_if / efwa_result_if
// Valid/ready channels carrying job items in and assignment items out.
// ----------------------------------------------------------------------------
interface efwa_job_if;
	logic                       valid;
	logic                       ready;
	logic [efwa_pkg::DUR_W-1:0] job_duration;

	modport source (output valid, output job_duration, input ready);
	modport sink   (input valid, input job_duration, output ready);
endinterface

interface efwa_result_if;
	logic                        valid;
	logic                        ready;
	logic [efwa_pkg::IDX_W-1:0]  worker_index;
	logic [efwa_pkg::TIME_W-1:0] start_time;

	modport source (output valid, output worker_index, output start_time, input ready);
	modport sink   (input valid, input worker_index, input start_time, output ready);
endinterface

### rtl/core/efwa_datapath.sv
// ----------------------------------------------------------------------------
// efwa_datapath
// Free-time registers, sequential minimum scan, saturating update and the
// output register.
// ----------------------------------------------------------------------------
module efwa_datapath #(
	parameter int MAX_WORKERS = efwa_pkg::MAX_WORKERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [efwa_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic [efwa_pkg::DUR_W-1:0]    job_duration,
	input  efwa_pkg::cmd_t                cmd,
	output efwa_pkg::sts_t                sts,
	input  logic                          res_ready,
	output logic                          res_valid,
	output logic [efwa_pkg::IDX_W-1:0]    worker_index,
	output logic [efwa_pkg::TIME_W-1:0]   start_time
);

	// Only workers reachable through the count register are stored.
	localparam int CountMax = (2 ** efwa_pkg::COUNT_W) - 1;
	localparam int Depth    = (MAX_WORKERS < CountMax) ? MAX_WORKERS : CountMax;
	localparam int SelW     = (Depth > 1) ? $clog2(Depth) : 1;

	logic [efwa_pkg::COUNT_W-1:0] count_q;
	logic [efwa_pkg::COUNT_W-1:0] active;
	logic [SelW-1:0]              last_sel;
	logic [efwa_pkg::TIME_W-1:0]  free_time_q [Depth];
	logic [efwa_pkg::DUR_W-1:0]   dur_q;
	logic [SelW-1:0]              sel_q;
	logic [SelW-1:0]              best_sel_q;
	logic [efwa_pkg::TIME_W-1:0]  best_time_q;
	logic [efwa_pkg::TIME_W-1:0]  rd_time;
	logic                         take;
	logic [efwa_pkg::TIME_W:0]    sum;
	logic [efwa_pkg::TIME_W-1:0]  new_time;
	logic                         out_valid_q;
	logic [efwa_pkg::IDX_W-1:0]   worker_index_q;
	logic [efwa_pkg::TIME_W-1:0]  start_time_q;

	// Worker count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= efwa_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Number of workers searched: zero means one, and the count is capped at the
	// number built.
	always_comb begin
		if (count_q == '0) begin
			active = efwa_pkg::COUNT_W'(1);
		end else if (int'(count_q) > Depth) begin
			active = efwa_pkg::COUNT_W'(Depth);
		end else begin
			active = count_q;
		end
	end

	assign last_sel = SelW'(active - efwa_pkg::COUNT_W'(1));

	// Entry under examination and the running-minimum decision. A strict
	// comparison keeps the lowest index on a tie.
	assign rd_time = free_time_q[sel_q];
	assign take    = (sel_q == '0) || (rd_time < best_time_q);

	// Saturating free-time update for the chosen worker.
	assign sum      = {1'b0, best_time_q} + (efwa_pkg::TIME_W + 1)'(dur_q);
	assign new_time = sum[efwa_pkg::TIME_W] ? efwa_pkg::TIME_MAX
		: sum[efwa_pkg::TIME_W-1:0];

	// Item capture and scan registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (cmd.load) begin
			sel_q <= '0;
		end else if (cmd.scan) begin
			sel_q <= sel_q + SelW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dur_q <= job_duration;
		end
		if (cmd.scan && take) begin
			best_sel_q  <= sel_q;
			best_time_q <= rd_time;
		end
	end

	// Free-time registers, all zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Depth; i++) begin
				free_time_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			free_time_q[best_sel_q] <= new_time;
		end
	end

	// Output register: holds a result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			worker_index_q <= efwa_pkg::IDX_W'(best_sel_q);
			start_time_q   <= best_time_q;
		end
	end

	// Status back to the controller.
	assign sts.scan_last = (sel_q == last_sel);
	assign sts.out_free  = !out_valid_q || res_ready;

	assign res_valid    = out_valid_q;
	assign worker_index = worker_index_q;
	assign start_time   = start_time_q;

endmodule

### rtl/core/efwa_ctrl.sv
// ----------------------------------------------------------------------------
// efwa_ctrl
// Sequencer: accepts an item, steps the scan over the active workers and
// commits the result when the output register has room.
// ----------------------------------------------------------------------------
module efwa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  efwa_pkg::sts_t sts,
	output efwa_pkg::cmd_t cmd
);

	efwa_pkg::state_t state_q;
	efwa_pkg::state_t state_d;
	logic             commit;
	logic             ready;

	// A new item is taken when idle, or in the cycle that the previous one commits.
	assign commit = (state_q == efwa_pkg::ST_UPDATE) && sts.out_free;
	assign ready  = (state_q == efwa_pkg::ST_IDLE) || commit;

	assign cmd.load   = job_valid && ready;
	assign cmd.scan   = (state_q == efwa_pkg::ST_SCAN);
	assign cmd.commit = commit;
	assign job_ready  = ready;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			efwa_pkg::ST_IDLE: begin
				if (job_valid) begin
					state_d = efwa_pkg::ST_SCAN;
				end
			end
			efwa_pkg::ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = efwa_pkg::ST_UPDATE;
				end
			end
			efwa_pkg::ST_UPDATE: begin
				if (sts.out_free) begin
					state_d = job_valid ? efwa_pkg::ST_SCAN : efwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = efwa_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/earliest_free_worker_assigner_unit.sv
// ----------------------------------------------------------------------------
// earliest_free_worker_assigner_unit
// Assigns each job to the worker that becomes free earliest and reports the
// chosen worker and the job's start time.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload                          Handshake
// job       in         job_duration[31:0]               valid/ready
// result    out        worker_index[3:0], start_time[47:0]  valid/ready
// cfg       in         cfg_wdata[4:0] (worker count)    cfg_we, no wait
//
// Each item is scanned over the N active workers, N being the active worker
// count, one free-time register per cycle; then the chosen worker's free
// time is written back with a saturating add.
// The next item is accepted in the write-back cycle, so it overlaps with the
// result waiting in the output register.
// A stalled result only holds the write-back of the following item.
// Reset clears all free times to zero and sets the worker count to one.
// ----------------------------------------------------------------------------
`include "earliest_free_worker_assigner_unit_assert.svh"

module earliest_free_worker_assigner_unit #(
	parameter int MAX_WORKERS = efwa_pkg::MAX_WORKERS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [efwa_pkg::COUNT_W-1:0] cfg_wdata,
	efwa_job_if.sink                     job,
	efwa_result_if.source                result
);

	efwa_pkg::cmd_t cmd;
	efwa_pkg::sts_t sts;

	// Sequencer.
	efwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job.valid),
		.job_ready (job.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Free-time storage, scan and output register.
	efwa_datapath #(
		.MAX_WORKERS (MAX_WORKERS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.job_duration (job.job_duration),
		.cmd          (cmd),
		.sts          (sts),
		.res_ready    (result.ready),
		.res_valid    (result.valid),
		.worker_index (result.worker_index),
		.start_time   (result.start_time)
	);

	// An accepted item always starts a scan in the following cycle.
	`EFWA_ASSERT_NEXT(a_load_starts_scan, cmd.load, cmd.scan && !job.ready, "no scan after item")
	// A result appears only after a commit.
	`EFWA_ASSERT_SAME(a_valid_commit, $rose(result.valid), $past(cmd.commit), "stray result")
	// A commit never overwrites a result that is still waiting.
	`EFWA_ASSERT_SAME(a_no_overwrite, cmd.commit && result.valid, result.ready, "overwrite")

endmodule

### bench/tb_earliest_free_worker_assigner_unit.sv
// ----------------------------------------------------------------------------
// tb_earliest_free_worker_assigner_unit
// Self-checking bench for the earliest-free worker assigner. Job items are
// offered with random gaps and results are taken with random stalls. A
// scoreboard keeps its own copy of every worker's free time, works out the
// expected worker and start time of each accepted job, and compares every
// result item in order. The worker count is changed between phases. Later
// phases cover an input stall while results are held off, and a run of the
// largest durations on a single worker.
// ----------------------------------------------------------------------------
module tb_earliest_free_worker_assigner_unit;

	localparam int LONG_HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES    = 20;
	localparam int PHASE_JOBS       = 48;
	localparam int BURST_JOBS       = 40;
	localparam int LARGE_JOBS       = 10;
	localparam int REPORT_LIMIT     = 30;

	localparam logic [efwa_pkg::DUR_W-1:0] DUR_MAX = '1;

	// Expected assignments of the accepted jobs whose results are still to come.
	class assignment_scoreboard;
		typedef struct packed {
			logic [efwa_pkg::IDX_W-1:0]  worker_index;
			logic [efwa_pkg::TIME_W-1:0] start_time;
		} assignment_t;

		logic [efwa_pkg::TIME_W-1:0]  free_time [efwa_pkg::MAX_WORKERS_DEF];
		logic [efwa_pkg::COUNT_W-1:0] worker_count;
		assignment_t                  pending_assignments [$];
		int                           mismatches;
		int                           jobs_noted;
		int                           results_checked;

		function void clear();
			foreach (free_time[i])
				free_time[i] = '0;
			worker_count = efwa_pkg::COUNT_RESET;
			pending_assignments.delete();
			mismatches = 0;
			jobs_noted = 0;
			results_checked = 0;
		endfunction

		function void set_worker_count(logic [efwa_pkg::COUNT_W-1:0] value);
			worker_count = value;
		endfunction

		// Picks the earliest-free active worker, lowest index on a tie, and books
		// the job on it with a saturating add.
		function void note_job(logic [efwa_pkg::DUR_W-1:0] duration);
			int                          active;
			int                          best;
			int                          i;
			logic [efwa_pkg::TIME_W:0]   sum;
			assignment_t                 booked;
			if (worker_count == 0)
				active = 1;
			else if (int'(worker_count) > efwa_pkg::MAX_WORKERS_DEF)
				active = efwa_pkg::MAX_WORKERS_DEF;
			else
				active = int'(worker_count);
			best = 0;
			for (i = 1; i < active; i++) begin
				if (free_time[i] < free_time[best])
					best = i;
			end
			booked.worker_index = efwa_pkg::IDX_W'(best);
			booked.start_time = free_time[best];
			sum = {1'b0, free_time[best]} + (efwa_pkg::TIME_W + 1)'(duration);
			free_time[best] = sum[efwa_pkg::TIME_W] ? efwa_pkg::TIME_MAX
				: sum[efwa_pkg::TIME_W-1:0];
			pending_assignments = {pending_assignments, booked};
			jobs_noted++;
		endfunction

		// Compares one result item with the oldest expected assignment.
		function void check_result(logic [efwa_pkg::IDX_W-1:0] worker_index,
				logic [efwa_pkg::TIME_W-1:0] start_time);
			assignment_t wanted;
			results_checked++;
			if (pending_assignments.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$error("result item with no job waiting: worker_index %0d start_time %0d",
						worker_index, start_time);
				return;
			end
			wanted = pending_assignments.pop_front();
			if (worker_index !== wanted.worker_index) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$error("worker_index: expected %0d, actual %0d",
						wanted.worker_index, worker_index);
			end
			if (start_time !== wanted.start_time) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$error("start_time: expected %0d, actual %0d",
						wanted.start_time, start_time);
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [efwa_pkg::COUNT_W-1:0] cfg_wdata;

	efwa_job_if    job_ch ();
	efwa_result_if result_ch ();

	assignment_scoreboard sb = new;

	int send_gap_max;
	int take_gap_max;
	bit long_hold_req;

	earliest_free_worker_assigner_unit #(
		.MAX_WORKERS(efwa_pkg::MAX_WORKERS_DEF)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.job      (job_ch),
		.result   (result_ch)
	);

	// Free-running clock, period ten.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog for a block that hangs.
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

	// Durations lean towards tiny values so that free times tie often.
	function automatic logic [efwa_pkg::DUR_W-1:0] draw_duration();
		unique case ($urandom_range(0, 9))
			0, 1, 2, 3: return efwa_pkg::DUR_W'($urandom_range(0, 3));
			4, 5, 6:    return efwa_pkg::DUR_W'($urandom_range(0, 1000));
			default:    return efwa_pkg::DUR_W'($urandom());
		endcase
	endfunction

	// Offers one job item after a gap and waits for it to be taken.
	task automatic offer_job(input logic [efwa_pkg::DUR_W-1:0] duration, input int gap);
		if (gap > 0) begin
			job_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		job_ch.valid <= 1'b1;
		job_ch.job_duration <= duration;
		@(posedge clk);
		while (!job_ch.ready)
			@(posedge clk);
		sb.note_job(duration);
	endtask

	task automatic offer_random_jobs(input int n);
		repeat (n)
			offer_job(draw_duration(), $urandom_range(0, send_gap_max));
	endtask

	// Lets every expected result arrive, then lets the block settle.
	task automatic wait_idle();
		job_ch.valid <= 1'b0;
		while (sb.pending_assignments.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Changes the worker count while nothing is in flight.
	task automatic write_worker_count(input logic [efwa_pkg::COUNT_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_worker_count(value);
	endtask

	// Result side: random stalls, and one long hold when asked for.
	initial begin
		int wait_cycles;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				wait_cycles = LONG_HOLD_CYCLES;
				long_hold_req = 1'b0;
			end else begin
				wait_cycles = $urandom_range(0, take_gap_max);
			end
			if (wait_cycles > 0) begin
				result_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			sb.check_result(result_ch.worker_index, result_ch.start_time);
		end
	end

	// Main sequence.
	initial begin
		int unsigned count_plan [11];
		int p;
		count_plan = '{2, 16, 1, 5, 0, 31, 8, 3, 16, 12, 20};
		sb.clear();
		send_gap_max = 19;
		take_gap_max = 19;
		long_hold_req = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		job_ch.valid <= 1'b0;
		job_ch.job_duration <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One worker after reset: extremes of the duration.
		offer_job('0, 0);
		offer_job(DUR_MAX, 0);
		offer_job(efwa_pkg::DUR_W'(1), 3);
		offer_job(32'h8000_0000, 0);

		// All sixteen workers: ties go to the lowest index.
		write_worker_count(efwa_pkg::COUNT_W'(16));
		offer_job('0, 0);
		offer_job('0, 2);
		offer_job(efwa_pkg::DUR_W'(7), 0);
		offer_job(efwa_pkg::DUR_W'(3), 0);
		offer_job(efwa_pkg::DUR_W'(5), 1);

		// A zero count acts as one worker; counts past the maximum saturate.
		write_worker_count(efwa_pkg::COUNT_W'(0));
		offer_job(efwa_pkg::DUR_W'(9), 0);
		offer_job('0, 0);
		write_worker_count(efwa_pkg::COUNT_W'(31));
		offer_job(efwa_pkg::DUR_W'(2), 0);
		offer_job(DUR_MAX, 4);
		write_worker_count(efwa_pkg::COUNT_W'(17));
		offer_job(efwa_pkg::DUR_W'(1), 0);
		write_worker_count(efwa_pkg::COUNT_W'(2));
		offer_job(efwa_pkg::DUR_W'(6), 0);

		// Random phases over a range of counts, with and without idling.
		for (p = 0; p < $size(count_plan); p++) begin
			write_worker_count(efwa_pkg::COUNT_W'(count_plan[p]));
			send_gap_max = (p % 3 == 2) ? 0 : 19;
			take_gap_max = (p % 4 == 1) ? 0 : 19;
			offer_random_jobs(PHASE_JOBS);
		end
		write_worker_count(efwa_pkg::COUNT_W'($urandom_range(0, 31)));
		offer_random_jobs(PHASE_JOBS);

		// Results held off while jobs keep coming, so the input stalls.
		write_worker_count(efwa_pkg::COUNT_W'(16));
		send_gap_max = 0;
		take_gap_max = 0;
		long_hold_req = 1'b1;
		offer_random_jobs(BURST_JOBS);

		// Pile the largest durations onto worker zero.
		write_worker_count(efwa_pkg::COUNT_W'(1));
		repeat (LARGE_JOBS)
			offer_job(DUR_MAX, 0);
		write_worker_count(efwa_pkg::COUNT_W'(2));
		send_gap_max = 19;
		take_gap_max = 19;
		offer_random_jobs(5);
		write_worker_count(efwa_pkg::COUNT_W'(16));
		offer_random_jobs(5);

		wait_idle();
		$display("Covered %0d jobs over worker counts 0 to 31, with ties, an input stall",
			sb.jobs_noted);
		$display("and runs of the largest duration; %0d results checked, %0d mismatches.",
			sb.results_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_assignments.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### earliest_free_worker_assigner_unit.f
+incdir+rtl/core
rtl/core/efwa_pkg.sv
rtl/core/efwa_if.sv
rtl/core/efwa_datapath.sv
rtl/core/efwa_ctrl.sv
rtl/core/earliest_free_worker_assigner_unit.sv
bench/tb_earliest_free_worker_assigner_unit.sv
